[rtl/tlds_pkg.sv]
package tlds_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 14;
    localparam int VALUE_W = 14;
    localparam int NODE_W  = 10;
    localparam int SCORE_W = 32;
    localparam int CFG_W   = 16;
    localparam int NUMN_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROW  = 2'd0,
        CMD_NBR  = 2'd1,
        CMD_RUN  = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic {
        KIND_RUN  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef enum logic {
        REG_NUM_NODES = 1'b0,
        REG_ITER      = 1'b1
    } reg_idx_t;

    localparam logic [CFG_W-1:0] ITER_RESET = 16'd100;

endpackage

[rtl/triangle_load_density_scores.sv]
// Channel | Dir | Handshake                  | Payload
// s_      | in  | s_tvalid / s_tready        | tuser: command; tdata: index, value
// m_      | out | m_tvalid / m_tready        | tuser: kind; tdata: node, score
// cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Read requests for a node in range go through the score RAM port; loads write directly.
// A run clears all MAX_NODES scores, then in each pass walks the configured nodes: it marks
// the valid neighbours of i, scans the entries of each valid neighbour j and scores each
// triangle found, then unmarks; a wrap step ends each pass, and a result on m_ ends the run.
// After reset a sweep over all MAX_NODES addresses clears scores and marks; s_tready is low.
// s_tready stays low while a result waits on m_; cfg_ready is always high.
module triangle_load_density_scores #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic [31:0] s_tdata,   // [13:0] index, [27:14] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [0:0]  m_tuser,   // [0] kind
    output logic [47:0] m_tdata,   // [9:0] node, [41:10] score
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int PW  = $clog2(MAX_EDGES + 1);
    localparam int VW  = tlds_pkg::VALUE_W;
    localparam int SW  = tlds_pkg::SCORE_W;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_RDS, S_RCLR, S_NODE, S_ROW0, S_ROW1, S_ROW2, S_MSET,
        S_J, S_J1, S_K, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_MCLR, S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [NCW-1:0]                  cnt_reg, cnt_next;
    logic [NCW-1:0]                  nn_reg, nn_next;
    logic [15:0]                     iter_reg, iter_next;
    logic [15:0]                     pass_reg, pass_next;
    logic [NCW-1:0]                  i_reg, i_next;
    logic [NCW-1:0]                  rown_reg, rown_next;
    logic                            jflag_reg, jflag_next;
    logic [VW-1:0]                   a_reg, a_next;
    logic [PW-1:0]                   loi_reg, loi_next, hii_reg, hii_next, hij_reg, hij_next;
    logic [PW-1:0]                   p_reg, p_next, pj_reg, pj_next, q_reg, q_next;
    logic                            pend_reg, pend_next;
    logic [NW-1:0]                   j_reg, j_next, k_reg, k_next;
    logic [SW-1:0]                   si_reg, si_next, sj_reg, sj_next;
    logic                            mv_reg, mv_next;
    logic                            mk_reg, mk_next;
    logic [tlds_pkg::NODE_W-1:0]     mn_reg, mn_next;
    logic [SW-1:0]                   ms_reg, ms_next;

    logic                            row_we, nb_we, sc_we, mk_we;
    logic [NCW-1:0]                  row_waddr, row_raddr;
    logic [VW-1:0]                   row_wdata, row_rdata;
    logic [EW-1:0]                   nb_waddr, nb_raddr;
    logic [VW-1:0]                   nb_wdata, nb_rdata;
    logic [NW-1:0]                   sc_waddr, sc_raddr, mk_waddr, mk_raddr;
    logic [SW-1:0]                   sc_wdata, sc_rdata;
    logic                            mk_wdata, mk_rdata;

    logic                            s_hand;
    logic [1:0]                      cmd;
    logic [tlds_pkg::INDEX_W-1:0]    idx;
    logic [VW-1:0]                   val;
    logic [PW-1:0]                   ac, bc, lo;
    logic                            nb_ok;
    logic [SW-1:0]                   tgt;

    assign cmd       = s_tuser;
    assign idx       = s_tdata[13:0];
    assign val       = s_tdata[27:14];
    assign s_tready  = (state_reg == S_IDLE) && !mv_reg;
    assign s_hand    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tuser   = mk_reg;
    assign m_tdata   = {6'd0, ms_reg, mn_reg};

    assign ac    = (32'(a_reg) > 32'(MAX_EDGES)) ? PW'(MAX_EDGES) : PW'(a_reg);
    assign bc    = (32'(row_rdata) > 32'(MAX_EDGES)) ? PW'(MAX_EDGES) : PW'(row_rdata);
    assign lo    = (ac > bc) ? bc : ac;
    assign nb_ok = 32'(nb_rdata) < 32'(nn_reg);

    tlds_ram #(.WIDTH(VW), .DEPTH(MAX_NODES + 1)) u_row (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    tlds_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_nbr (
        .aclk(aclk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );
    tlds_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_score (
        .aclk(aclk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
        .raddr(sc_raddr), .rdata(sc_rdata)
    );
    tlds_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
        .aclk(aclk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        nn_next    = nn_reg;
        iter_next  = iter_reg;
        pass_next  = pass_reg;
        i_next     = i_reg;
        rown_next  = rown_reg;
        jflag_next = jflag_reg;
        a_next     = a_reg;
        loi_next   = loi_reg;
        hii_next   = hii_reg;
        hij_next   = hij_reg;
        p_next     = p_reg;
        pj_next    = pj_reg;
        q_next     = q_reg;
        pend_next  = pend_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        mv_next    = mv_reg && !m_tready;
        mk_next    = mk_reg;
        mn_next    = mn_reg;
        ms_next    = ms_reg;
        row_we     = 1'b0;
        row_waddr  = NCW'(idx);
        row_wdata  = val;
        row_raddr  = rown_reg;
        nb_we      = 1'b0;
        nb_waddr   = EW'(idx);
        nb_wdata   = val;
        nb_raddr   = EW'(p_reg);
        sc_we      = 1'b0;
        sc_waddr   = NW'(cnt_reg);
        sc_wdata   = '0;
        sc_raddr   = NW'(i_reg);
        mk_we      = 1'b0;
        mk_waddr   = NW'(nb_rdata);
        mk_wdata   = 1'b0;
        mk_raddr   = NW'(nb_rdata);
        tgt        = '0;

        if (cfg_valid) begin
            if (cfg_index == tlds_pkg::REG_NUM_NODES) begin
                nn_next = (32'(cfg_data[10:0]) > 32'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                                 : NCW'(cfg_data[10:0]);
            end else begin
                iter_next = cfg_data;
            end
        end

        case (state_reg)
            S_INIT: begin
                sc_we    = 1'b1;
                mk_we    = 1'b1;
                mk_waddr = NW'(cnt_reg);
                cnt_next = NCW'(cnt_reg + 1'b1);
                if (cnt_reg == NCW'(MAX_NODES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_hand) begin
                    case (cmd)
                        tlds_pkg::CMD_ROW: begin
                            row_we = 32'(idx) <= 32'(MAX_NODES);
                        end
                        tlds_pkg::CMD_NBR: begin
                            nb_we = 32'(idx) < 32'(MAX_EDGES);
                        end
                        tlds_pkg::CMD_RUN: begin
                            cnt_next   = '0;
                            state_next = S_RCLR;
                        end
                        default: begin
                            mn_next = idx[9:0];
                            mk_next = tlds_pkg::KIND_READ;
                            if (32'(idx) < 32'(MAX_NODES)) begin
                                sc_raddr   = NW'(idx);
                                state_next = S_RDS;
                            end else begin
                                ms_next = '0;
                                mv_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RDS: begin
                ms_next    = sc_rdata;
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_RCLR: begin
                sc_we    = 1'b1;
                cnt_next = NCW'(cnt_reg + 1'b1);
                if (cnt_reg == NCW'(MAX_NODES - 1)) begin
                    pass_next  = '0;
                    i_next     = '0;
                    state_next = S_NODE;
                end
            end
            S_NODE: begin
                if (pass_reg == iter_reg) begin
                    state_next = S_DONE;
                end else if (i_reg == nn_reg) begin
                    pass_next = pass_reg + 16'd1;
                    i_next    = '0;
                end else begin
                    rown_next  = i_reg;
                    jflag_next = 1'b0;
                    state_next = S_ROW0;
                end
            end
            S_ROW0: begin
                state_next = S_ROW1;
            end
            S_ROW1: begin
                row_raddr  = NCW'(rown_reg + 1'b1);
                a_next     = row_rdata;
                state_next = S_ROW2;
            end
            S_ROW2: begin
                if (!jflag_reg) begin
                    loi_next   = lo;
                    hii_next   = bc;
                    p_next     = lo;
                    pend_next  = 1'b0;
                    state_next = S_MSET;
                end else begin
                    q_next     = lo;
                    hij_next   = bc;
                    state_next = S_K;
                end
            end
            S_MSET, S_MCLR: begin
                // mark (or unmark) each valid neighbour of i as its entry arrives
                mk_we    = pend_reg && nb_ok;
                mk_wdata = (state_reg == S_MSET);
                if (p_reg < hii_reg) begin
                    p_next    = PW'(p_reg + 1'b1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (state_reg == S_MSET) begin
                            pj_next    = loi_reg;
                            state_next = S_J;
                        end else begin
                            i_next     = NCW'(i_reg + 1'b1);
                            state_next = S_NODE;
                        end
                    end
                end
            end
            S_J: begin
                nb_raddr = EW'(pj_reg);
                if (pj_reg < hii_reg) begin
                    state_next = S_J1;
                end else begin
                    p_next     = loi_reg;
                    pend_next  = 1'b0;
                    state_next = S_MCLR;
                end
            end
            S_J1: begin
                if (nb_ok) begin
                    j_next     = NW'(nb_rdata);
                    rown_next  = NCW'(nb_rdata);
                    jflag_next = 1'b1;
                    state_next = S_ROW0;
                end else begin
                    pj_next    = PW'(pj_reg + 1'b1);
                    state_next = S_J;
                end
            end
            S_K: begin
                nb_raddr = EW'(q_reg);
                if (q_reg < hij_reg) begin
                    state_next = S_K1;
                end else begin
                    pj_next    = PW'(pj_reg + 1'b1);
                    state_next = S_J;
                end
            end
            S_K1: begin
                if (nb_ok) begin
                    k_next     = NW'(nb_rdata);
                    state_next = S_K2;
                end else begin
                    q_next     = PW'(q_reg + 1'b1);
                    state_next = S_K;
                end
            end
            S_K2: begin
                if (mk_rdata) begin
                    state_next = S_K3;
                end else begin
                    q_next     = PW'(q_reg + 1'b1);
                    state_next = S_K;
                end
            end
            S_K3: begin
                si_next    = sc_rdata;
                sc_raddr   = j_reg;
                state_next = S_K4;
            end
            S_K4: begin
                sj_next    = sc_rdata;
                sc_raddr   = k_reg;
                state_next = S_K5;
            end
            S_K5: begin
                sc_raddr   = k_reg;
                state_next = S_K6;
            end
            S_K6: begin
                // least score takes the triangle, ties to i then j
                if (si_reg <= sj_reg && si_reg <= sc_rdata) begin
                    sc_waddr = NW'(i_reg);
                    tgt      = si_reg;
                end else if (sj_reg <= sc_rdata) begin
                    sc_waddr = j_reg;
                    tgt      = sj_reg;
                end else begin
                    sc_waddr = k_reg;
                    tgt      = sc_rdata;
                end
                sc_we      = ~&tgt;
                sc_wdata   = tgt + 1'b1;
                q_next     = PW'(q_reg + 1'b1);
                state_next = S_K;
            end
            S_DONE: begin
                mk_next    = tlds_pkg::KIND_RUN;
                mn_next    = '0;
                ms_next    = '0;
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            nn_reg    <= '0;
            iter_reg  <= tlds_pkg::ITER_RESET;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nn_reg    <= nn_next;
            iter_reg  <= iter_next;
            mv_reg    <= mv_next;
            pend_reg  <= pend_next;
        end
        pass_reg  <= pass_next;
        i_reg     <= i_next;
        rown_reg  <= rown_next;
        jflag_reg <= jflag_next;
        a_reg     <= a_next;
        loi_reg   <= loi_next;
        hii_reg   <= hii_next;
        hij_reg   <= hij_next;
        p_reg     <= p_next;
        pj_reg    <= pj_next;
        q_reg     <= q_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        si_reg    <= si_next;
        sj_reg    <= sj_next;
        mk_reg    <= mk_next;
        mn_reg    <= mn_next;
        ms_reg    <= ms_next;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request accepted while a result is pending");

    a_run_starts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hand && cmd == tlds_pkg::CMD_RUN) |=> state_reg == S_RCLR)
        else $error("run request did not start the score clear");

    a_mark_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mk_we |-> (state_reg == S_MSET || state_reg == S_MCLR || state_reg == S_INIT))
        else $error("mark write outside mark sweep");

    a_bump_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_we && state_reg == S_K6) |-> sc_wdata != '0)
        else $error("score bump wrote zero");
`endif

endmodule

[rtl/tlds_ram.sv]
module tlds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int NODES   = 1024;
    localparam int EDGES   = 8192;
    localparam int LIMIT   = 20000000;
    localparam int HOLD_CY = 3000;
    localparam int ITEMS   = 1250;

    typedef struct packed {
        tlds_pkg::cmd_t               cmd;
        logic [tlds_pkg::INDEX_W-1:0] idx;
        logic [tlds_pkg::VALUE_W-1:0] val;
    } request_t;

    typedef struct packed {
        tlds_pkg::kind_t              kind;
        logic [tlds_pkg::NODE_W-1:0]  node;
        logic [tlds_pkg::SCORE_W-1:0] score;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [0:0]  m_tuser;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    triangle_load_density_scores u_top (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // graph copy and scores as the block should hold them
    logic [tlds_pkg::VALUE_W-1:0] row_off [0:NODES];
    logic [tlds_pkg::VALUE_W-1:0] nbr_ent [0:EDGES-1];
    logic [tlds_pkg::SCORE_W-1:0] load_score [0:NODES-1];
    logic                         nbr_mark [0:NODES-1];
    int                           num_nodes_q = 0;
    int                           iter_q = int'(tlds_pkg::ITER_RESET);

    request_t pending_q[$];
    answer_t  answer_q[$];
    request_t cur_req;
    int       errors = 0;
    int       cycles = 0;
    int       s_gap = 0;
    int       m_gap = 0;
    int       n_sent = 0;
    bit       no_idle = 0;
    bit       hold_req = 0;
    bit       hold_done = 0;
    int       hold_cnt = 0;
    bit       s_taken = 0;

    function automatic void row_bounds(input int n, output int lo, output int hi);
        lo = int'(row_off[n]);
        hi = int'(row_off[n+1]);
        if (lo > EDGES) lo = EDGES;
        if (hi > EDGES) hi = EDGES;
        if (lo > hi) lo = hi;
    endfunction

    function automatic void raise_load(input int n);
        if (load_score[n] != '1) load_score[n] = load_score[n] + 1;
    endfunction

    function automatic void run_triangle_passes();
        int nn, lo, hi, lo2, hi2, j, k;
        nn = num_nodes_q > NODES ? NODES : num_nodes_q;
        for (int n = 0; n < NODES; n++) load_score[n] = '0;
        for (int ps = 0; ps < iter_q; ps++) begin
            for (int i = 0; i < nn; i++) begin
                row_bounds(i, lo, hi);
                for (int p = lo; p < hi; p++)
                    if (nbr_ent[p] < nn) nbr_mark[nbr_ent[p]] = 1'b1;
                for (int p = lo; p < hi; p++) begin
                    j = int'(nbr_ent[p]);
                    if (j < nn) begin
                        row_bounds(j, lo2, hi2);
                        for (int q = lo2; q < hi2; q++) begin
                            k = int'(nbr_ent[q]);
                            if (k < nn && nbr_mark[k]) begin
                                if (load_score[i] <= load_score[j] &&
                                    load_score[i] <= load_score[k]) raise_load(i);
                                else if (load_score[j] <= load_score[i] &&
                                         load_score[j] <= load_score[k]) raise_load(j);
                                else raise_load(k);
                            end
                        end
                    end
                end
                for (int p = lo; p < hi; p++)
                    if (nbr_ent[p] < nn) nbr_mark[nbr_ent[p]] = 1'b0;
            end
        end
    endfunction

    function automatic void predict_request(input request_t r);
        answer_t a;
        case (r.cmd)
            tlds_pkg::CMD_ROW: if (r.idx <= NODES) row_off[r.idx] = r.val;
            tlds_pkg::CMD_NBR: if (r.idx < EDGES) nbr_ent[r.idx] = r.val;
            tlds_pkg::CMD_RUN: begin
                run_triangle_passes();
                a.kind = tlds_pkg::KIND_RUN;
                a.node = '0;
                a.score = '0;
                answer_q = {answer_q, a};
            end
            default: begin
                a.kind = tlds_pkg::KIND_READ;
                a.node = r.idx[tlds_pkg::NODE_W-1:0];
                a.score = r.idx < NODES ? load_score[r.idx] : '0;
                answer_q = {answer_q, a};
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // accept requests and check answers
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && s_tvalid && s_tready) predict_request(cur_req);
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected answer kind=%0d node=%0d score=%0d",
                       m_tuser[0], m_tdata[9:0], m_tdata[41:10]);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (m_tuser[0] !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[9:0] !== want.node) begin
                    $error("node: expected %0d, got %0d", want.node, m_tdata[9:0]);
                    errors++;
                end
                if (m_tdata[41:10] !== want.score) begin
                    $error("score: expected %0d, got %0d", want.score, m_tdata[41:10]);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_taken)) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_req = pending_q.pop_front();
                s_tuser <= cur_req.cmd;
                s_tdata <= {4'b0, cur_req.val, cur_req.idx};
                s_tvalid <= 1'b1;
                s_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) s_taken <= s_tvalid && s_tready;

    // answer receiver, with one long hold-off once a result is offered
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && !hold_done && m_tvalid) begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CY;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_gap <= pick_gap();
            end
        end
    end

    task automatic push(input tlds_pkg::cmd_t c, input int i, input int v);
        request_t r;
        r.cmd = c;
        r.idx = 14'(i);
        r.val = 14'(v);
        pending_q = {pending_q, r};
        n_sent++;
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || s_tvalid || answer_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input tlds_pkg::reg_idx_t r, input int d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= 16'(d);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (r == tlds_pkg::REG_NUM_NODES) num_nodes_q = d & 16'h7FF;
        else iter_q = d & 16'hFFFF;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int nn, span, base, phase, lo, n;
        for (int e = 0; e < NODES; e++) begin
            load_score[e] = '0;
            nbr_mark[e] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: no nodes, default pass count
        push(tlds_pkg::CMD_RUN, 0, 0);
        push(tlds_pkg::CMD_READ, 0, 0);
        wait_idle();

        // full node range: one triangle, a clamped last row, dead entries
        write_reg(tlds_pkg::REG_NUM_NODES, NODES);
        write_reg(tlds_pkg::REG_ITER, 2);
        for (int e = 0; e <= NODES; e++)
            push(tlds_pkg::CMD_ROW, e, e == 0 ? 8184 : e == 1 ? 8186 : e == 2 ? 8188 :
                                       e == NODES ? 16383 : 8190);
        push(tlds_pkg::CMD_NBR, 8184, 1); push(tlds_pkg::CMD_NBR, 8185, 2);
        push(tlds_pkg::CMD_NBR, 8186, 0); push(tlds_pkg::CMD_NBR, 8187, 2);
        push(tlds_pkg::CMD_NBR, 8188, 0); push(tlds_pkg::CMD_NBR, 8189, 1);
        push(tlds_pkg::CMD_NBR, 8190, 0); push(tlds_pkg::CMD_NBR, 8191, 16383);
        push(tlds_pkg::CMD_ROW, 1025, 0); push(tlds_pkg::CMD_ROW, 16383, 16383);
        push(tlds_pkg::CMD_NBR, 8192, 3); push(tlds_pkg::CMD_NBR, 16383, 0);
        push(tlds_pkg::CMD_RUN, 0, 0);
        for (int e = 0; e < 4; e++) push(tlds_pkg::CMD_READ, e, 0);
        push(tlds_pkg::CMD_READ, 1023, 0); push(tlds_pkg::CMD_READ, 1024, 0);
        push(tlds_pkg::CMD_READ, 16383, 0);
        wait_idle();

        // oversized node count acts as the maximum; zero passes only clear
        write_reg(tlds_pkg::REG_NUM_NODES, 2047);
        push(tlds_pkg::CMD_RUN, 0, 0); push(tlds_pkg::CMD_READ, 0, 0);
        wait_idle();
        write_reg(tlds_pkg::REG_ITER, 0);
        push(tlds_pkg::CMD_RUN, 0, 0); push(tlds_pkg::CMD_READ, 1, 0);
        wait_idle();
        write_reg(tlds_pkg::REG_NUM_NODES, 0);
        write_reg(tlds_pkg::REG_ITER, 65535);
        push(tlds_pkg::CMD_RUN, 0, 0); push(tlds_pkg::CMD_READ, 2, 0);
        wait_idle();

        phase = 0;
        while (n_sent < ITEMS) begin
            nn = $urandom_range(1, 24);
            span = $urandom_range(nn, 4 * nn);
            base = $urandom_range(0, 8000);
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(tlds_pkg::REG_NUM_NODES, nn);
            write_reg(tlds_pkg::REG_ITER,
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
            if (phase == 0) hold_req = 1;
            // offsets land in any order inside the written span
            for (int e = 0; e <= nn; e++)
                push(tlds_pkg::CMD_ROW, e, base + $urandom_range(0, span));
            for (int e = 0; e < span; e++) begin
                push(tlds_pkg::CMD_NBR, base + e, $urandom_range(0, 99) < 85 ?
                     $urandom_range(0, nn - 1) : $urandom_range(0, 16383));
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, 2);
                    if (n == 0) push(tlds_pkg::CMD_ROW, $urandom_range(nn + 1, 16383),
                                     $urandom_range(0, 16383));
                    else if (n == 1) push(tlds_pkg::CMD_NBR, $urandom_range(0, 16383),
                                          $urandom_range(0, 16383));
                    else push(tlds_pkg::CMD_READ, $urandom_range(0, 16383),
                              $urandom_range(0, 16383));
                end
            end
            push(tlds_pkg::CMD_RUN, $urandom_range(0, 16383), $urandom_range(0, 16383));
            lo = $urandom_range(4, phase == 0 ? 30 : 12);
            for (int e = 0; e < lo; e++)
                push(tlds_pkg::CMD_READ, $urandom_range(0, 9) < 8 ? $urandom_range(0, nn - 1)
                                                                   : $urandom_range(0, 16383),
                     $urandom_range(0, 16383));
            wait_idle();
            phase++;
        end

        no_idle = 0;
        repeat (50) @(posedge aclk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tlds_pkg.sv
rtl/tlds_ram.sv
rtl/triangle_load_density_scores.sv
tb/tb.sv
